/* hdl/i2p_pkg.sv */
// ----------------------------------------------------------------------------
// i2p_pkg: shared types and helpers for the infix to postfix converter
// Operator codes, command format between front and back, stack control.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // ASCII codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_NONE   = 8'h00;

  typedef logic [2:0] opcode_t;

  localparam opcode_t OP_LPAREN = 3'd0;
  localparam opcode_t OP_ADD    = 3'd1;
  localparam opcode_t OP_SUB    = 3'd2;
  localparam opcode_t OP_MUL    = 3'd3;
  localparam opcode_t OP_DIV    = 3'd4;

  typedef enum logic [2:0] {
    K_LETTER,
    K_LPAREN,
    K_RPAREN,
    K_OPER,
    K_OTHER
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    opcode_t    op;
    logic [7:0] ch;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic    push;
    logic    pop;
    logic    clear;
    opcode_t code;
  } stk_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] parens;
    opcode_t          top;
    opcode_t          under;
  } stk_stat_t;

  typedef enum logic [0:0] {
    S_EXEC,
    S_FLUSH
  } state_t;

  function automatic logic [7:0] op_char(opcode_t code);
    logic [7:0] c;
    unique case (code)
      OP_LPAREN: c = CH_LPAREN;
      OP_ADD:    c = CH_ADD;
      OP_SUB:    c = CH_SUB;
      OP_MUL:    c = CH_MUL;
      OP_DIV:    c = CH_DIV;
      default:   c = CH_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] op_prio(opcode_t code);
    logic [1:0] p;
    unique case (code)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic cmd_t classify(logic [7:0] s, logic last);
    cmd_t c;
    c.ch   = s;
    c.last = last;
    c.op   = OP_LPAREN;
    priority if ((s >= CH_UP_A && s <= CH_UP_Z) || (s >= CH_LO_A && s <= CH_LO_Z)) begin
      c.kind = K_LETTER;
    end else if (s == CH_LPAREN) begin
      c.kind = K_LPAREN;
    end else if (s == CH_RPAREN) begin
      c.kind = K_RPAREN;
    end else if (s == CH_ADD) begin
      c.kind = K_OPER;
      c.op   = OP_ADD;
    end else if (s == CH_SUB) begin
      c.kind = K_OPER;
      c.op   = OP_SUB;
    end else if (s == CH_MUL) begin
      c.kind = K_OPER;
      c.op   = OP_MUL;
    end else if (s == CH_DIV) begin
      c.kind = K_OPER;
      c.op   = OP_DIV;
    end else begin
      c.kind = K_OTHER;
    end
    return c;
  endfunction

endpackage

/* hdl/i2p_front.sv */
// ----------------------------------------------------------------------------
// i2p_front: input word acceptance and symbol classification
// Decodes each character into a command and writes it to the queue.
// ----------------------------------------------------------------------------
module i2p_front import i2p_pkg::*; (
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  input  logic       in_tlast,
  output logic       q_push,
  output cmd_t       q_cmd,
  input  logic       q_full
);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign q_cmd     = classify(in_tdata, in_tlast);

endmodule

/* hdl/i2p_queue.sv */
// ----------------------------------------------------------------------------
// i2p_queue: small command FIFO between front and back
// Lets the front keep taking words while the back pops the stack.
// ----------------------------------------------------------------------------
module i2p_queue import i2p_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t rd_cmd
);

  cmd_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;

  assign full   = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign empty  = (fill_r == '0);
  assign rd_cmd = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   fill_nxt = fill_r + QCNT_W'(1);
      2'b01:   fill_nxt = fill_r - QCNT_W'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

/* hdl/i2p_stack.sv */
// ----------------------------------------------------------------------------
// i2p_stack: operator stack
// Memory with a cached top entry and a prefetched entry below it, so a pop
// every cycle sees the new top at once. Tracks how many '(' are held.
// ----------------------------------------------------------------------------
module i2p_stack import i2p_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  stk_ctl_t  ctl,
  output stk_stat_t stat
);

  opcode_t          mem [STACK_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] parens_r, parens_nxt;
  opcode_t          top_r, top_nxt;
  opcode_t          under_r;
  logic [CNT_W-1:0] rd_cnt;

  always_comb begin
    count_nxt  = count_r;
    parens_nxt = parens_r;
    top_nxt    = top_r;
    priority if (ctl.clear) begin
      count_nxt  = '0;
      parens_nxt = '0;
    end else if (ctl.push) begin
      count_nxt = count_r + CNT_W'(1);
      top_nxt   = ctl.code;
      if (ctl.code == OP_LPAREN) begin
        parens_nxt = parens_r + CNT_W'(1);
      end
    end else if (ctl.pop) begin
      count_nxt = count_r - CNT_W'(1);
      top_nxt   = under_r;
      if (top_r == OP_LPAREN) begin
        parens_nxt = parens_r - CNT_W'(1);
      end
    end
  end

  // entry below the next top; never the address written this cycle
  assign rd_cnt = count_nxt - CNT_W'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      parens_r <= '0;
    end else begin
      count_r  <= count_nxt;
      parens_r <= parens_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (ctl.push) begin
      mem[count_r[IDX_W-1:0]] <= ctl.code;
    end
    under_r <= mem[rd_cnt[IDX_W-1:0]];
  end

  assign stat.count  = count_r;
  assign stat.parens = parens_r;
  assign stat.top    = top_r;
  assign stat.under  = under_r;

endmodule

/* hdl/i2p_back.sv */
// ----------------------------------------------------------------------------
// i2p_back: shunting-yard sequencer and output register
// Executes queued commands against the stack, one push or pop per cycle unless
// the output is stalled, and flushes the stack at end of expression.
// ----------------------------------------------------------------------------
module i2p_back import i2p_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       head,
  output logic       q_pop,
  output stk_ctl_t   stk_ctl,
  input  stk_stat_t  stk,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [0] has_char, [1] overflow
);

  state_t           state_r, state_nxt;
  logic             ovf_r, ovf_nxt;
  logic             emitted_r, emitted_nxt;
  logic             ov_r;
  logic [7:0]       och_r;
  logic             ohas_r;
  logic             olast_r;
  logic             oovf_r;

  logic             slot_free;
  logic [CNT_W-1:0] ops;
  logic             stk_empty;
  logic             stk_full;
  logic             under_valid;
  logic             under_op;
  logic             under_cont;
  logic [1:0]       top_prio;
  logic [1:0]       cur_prio;

  logic             emit;
  logic [7:0]       e_char;
  logic             e_has;
  logic             e_last;
  logic             ovf_set;
  logic             finish;
  logic             flush_done;

  assign slot_free   = !ov_r || out_tready;
  assign ops         = stk.count - stk.parens;
  assign stk_empty   = (stk.count == '0);
  assign stk_full    = (stk.count == CNT_W'(STACK_DEPTH));
  assign under_valid = (stk.count > CNT_W'(1));
  assign top_prio    = op_prio(stk.top);
  assign cur_prio    = op_prio(head.op);
  assign under_op    = under_valid && (stk.under != OP_LPAREN);
  assign under_cont  = under_valid && (op_prio(stk.under) >= cur_prio);

  // actions of the current cycle
  always_comb begin
    emit       = 1'b0;
    e_char     = CH_NONE;
    e_has      = 1'b1;
    e_last     = 1'b0;
    ovf_set    = 1'b0;
    finish     = 1'b0;
    flush_done = 1'b0;
    stk_ctl    = '0;
    unique case (state_r)
      S_EXEC: begin
        if (!q_empty) begin
          unique case (head.kind)
            K_LETTER: begin
              if (slot_free) begin
                emit   = 1'b1;
                e_char = head.ch;
                e_last = !head.last || (ops == '0);
                finish = 1'b1;
              end
            end
            K_LPAREN: begin
              if (stk_full) begin
                ovf_set = 1'b1;
              end else begin
                stk_ctl.push = 1'b1;
                stk_ctl.code = OP_LPAREN;
              end
              finish = 1'b1;
            end
            K_RPAREN: begin
              if (stk_empty) begin
                finish = 1'b1;
              end else if (stk.top == OP_LPAREN) begin
                stk_ctl.pop = 1'b1;
                finish      = 1'b1;
              end else if (slot_free) begin
                emit        = 1'b1;
                e_char      = op_char(stk.top);
                stk_ctl.pop = 1'b1;
                // more output follows if the next entry is an operator, or the
                // end-of-expression flush will find operators below the '('
                e_last      = !(under_op || (head.last && ops > CNT_W'(1)));
              end
            end
            K_OPER: begin
              if (!stk_empty && top_prio >= cur_prio) begin
                if (slot_free) begin
                  emit        = 1'b1;
                  e_char      = op_char(stk.top);
                  stk_ctl.pop = 1'b1;
                  // at end, the operator pushed afterwards is flushed out too
                  e_last      = !(under_cont || head.last);
                end
              end else begin
                if (stk_full) begin
                  ovf_set = 1'b1;
                end else begin
                  stk_ctl.push = 1'b1;
                  stk_ctl.code = head.op;
                end
                finish = 1'b1;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (ops == '0) begin
          // only '(' left: drop them all at once
          if (!emitted_r) begin
            if (slot_free) begin
              emit          = 1'b1;
              e_char        = CH_NONE;
              e_has         = 1'b0;
              e_last        = 1'b1;
              stk_ctl.clear = 1'b1;
              flush_done    = 1'b1;
            end
          end else begin
            stk_ctl.clear = 1'b1;
            flush_done    = 1'b1;
          end
        end else if (stk.top == OP_LPAREN) begin
          stk_ctl.pop = 1'b1;
        end else if (slot_free) begin
          emit        = 1'b1;
          e_char      = op_char(stk.top);
          stk_ctl.pop = 1'b1;
          e_last      = (ops == CNT_W'(1));
        end
      end
      default: begin
        flush_done = 1'b1;
      end
    endcase
  end

  assign q_pop = finish;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_EXEC:  if (finish && head.last) state_nxt = S_FLUSH;
      S_FLUSH: if (flush_done) state_nxt = S_EXEC;
      default: state_nxt = S_EXEC;
    endcase
  end

  always_comb begin
    ovf_nxt     = ovf_r || ovf_set;
    emitted_nxt = emitted_r;
    if ((finish && !head.last) || flush_done) begin
      emitted_nxt = 1'b0;
    end else if (emit) begin
      emitted_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_EXEC;
      ovf_r     <= 1'b0;
      emitted_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ovf_r     <= ovf_nxt;
      emitted_r <= emitted_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // overflow can only be raised by a push, which comes before any later
  // word of the same item, so the live flag is the value after the item
  always_ff @(posedge clk) begin
    if (emit) begin
      och_r   <= e_char;
      ohas_r  <= e_has;
      olast_r <= e_last;
      oovf_r  <= ovf_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = och_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = {oovf_r, ohas_r};

  a_parens_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
    stk.parens <= stk.count)
    else $error("paren count exceeds stack count");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk.count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !ohas_r) |-> (olast_r && och_r == CH_NONE))
    else $error("empty marker not last or not zero");

  a_no_flush_emit_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |-> !q_pop)
    else $error("queue popped during flush");

endmodule

/* hdl/infix_to_postfix_converter.sv */
// An accepted word is written to the command queue; the back end takes it from
// there and registers each output word. Letters, '(' and ignored symbols need no
// pop; ')' and operators pop stack entries one at a time; end of expression pops
// entries down to the deepest operator (the '(' below it drop at once).
// Reset (rst_n low, synchronous) empties the stack, queue and output and
// clears the overflow flag; stack memory contents are not cleared.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard infix to postfix conversion
// Front classifies symbols into a queue; back runs the operator stack.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter import i2p_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  input  logic       in_tlast,   // end_of_expr
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,  // last_of_run
  output logic [1:0] out_tuser   // [0] has_char, [1] overflow
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  cmd_t      q_wr_cmd;
  cmd_t      q_head;
  stk_ctl_t  stk_ctl;
  stk_stat_t stk_stat;

  i2p_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_push    (q_push),
    .q_cmd     (q_wr_cmd),
    .q_full    (q_full)
  );

  i2p_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_cmd (q_head)
  );

  i2p_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .stat  (stk_stat)
  );

  i2p_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .head       (q_head),
    .q_pop      (q_pop),
    .stk_ctl    (stk_ctl),
    .stk        (stk_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: infix to postfix converter
// Streams infix expressions into the converter and predicts its postfix word
// stream with a shunting-yard model of its own. Directed corner cases first,
// then random expressions, broken token runs and noise bytes, with random
// idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2p_pkg::*;

  localparam int ITEMS = 420;
  localparam int LIMIT = 2_000_000;

  class postfix_scoreboard;
    typedef struct {
      logic [7:0] ch;
      logic       has_char;
      logic       run_last;
      logic       ovf;
    } postfix_word_t;

    opcode_t       op_stack [STACK_DEPTH];
    int            depth;
    bit            ovf_seen;
    postfix_word_t pending_q [$];
    int            errors;

    function new();
      depth    = 0;
      ovf_seen = 0;
      errors   = 0;
    endfunction

    function logic [7:0] glyph(opcode_t code);
      case (code)
        OP_ADD:  return CH_ADD;
        OP_SUB:  return CH_SUB;
        OP_MUL:  return CH_MUL;
        OP_DIV:  return CH_DIV;
        default: return CH_LPAREN;
      endcase
    endfunction

    function int rank(opcode_t code);
      case (code)
        OP_MUL, OP_DIV: return 2;
        OP_ADD, OP_SUB: return 1;
        default:        return 0;
      endcase
    endfunction

    function void push_op(opcode_t code);
      if (depth < STACK_DEPTH) begin
        op_stack[depth] = code;
        depth++;
      end else begin
        ovf_seen = 1;
      end
    endfunction

    // Work out the words one accepted input word causes.
    function void note_word(logic [7:0] sym, logic eoe);
      logic [8:0]    fresh [$];  // {has_char, char}
      postfix_word_t w;
      opcode_t       code;
      bit            is_op;
      is_op = 1;
      code  = OP_LPAREN;
      case (sym)
        CH_ADD:  code = OP_ADD;
        CH_SUB:  code = OP_SUB;
        CH_MUL:  code = OP_MUL;
        CH_DIV:  code = OP_DIV;
        default: is_op = 0;
      endcase
      if ((sym >= CH_UP_A && sym <= CH_UP_Z) || (sym >= CH_LO_A && sym <= CH_LO_Z)) begin
        fresh.push_back({1'b1, sym});
      end else if (sym == CH_LPAREN) begin
        push_op(OP_LPAREN);
      end else if (sym == CH_RPAREN) begin
        // unmatched ')' just drains the stack
        while (depth > 0) begin
          depth--;
          if (op_stack[depth] == OP_LPAREN) break;
          fresh.push_back({1'b1, glyph(op_stack[depth])});
        end
      end else if (is_op) begin
        while (depth > 0 && rank(op_stack[depth-1]) >= rank(code)) begin
          depth--;
          fresh.push_back({1'b1, glyph(op_stack[depth])});
        end
        push_op(code);
      end
      if (eoe) begin
        while (depth > 0) begin
          depth--;
          if (op_stack[depth] != OP_LPAREN) fresh.push_back({1'b1, glyph(op_stack[depth])});
        end
        if (fresh.size() == 0) fresh.push_back({1'b0, CH_NONE});
      end
      foreach (fresh[i]) begin
        w.ch       = fresh[i][7:0];
        w.has_char = fresh[i][8];
        w.run_last = (i == fresh.size() - 1);
        w.ovf      = ovf_seen;
        pending_q.push_back(w);
      end
    endfunction

    function void check_word(logic [7:0] data, logic tlast, logic [1:0] tuser);
      postfix_word_t w;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word: expected none, actual data=%h last=%b user=%b",
                 $time, data, tlast, tuser);
        return;
      end
      w = pending_q.pop_front();
      if (data !== w.ch) begin
        errors++;
        $display("%0t: out_char mismatch: expected %h, actual %h", $time, w.ch, data);
      end
      if (tuser[0] !== w.has_char) begin
        errors++;
        $display("%0t: has_char mismatch: expected %b, actual %b", $time, w.has_char, tuser[0]);
      end
      if (tlast !== w.run_last) begin
        errors++;
        $display("%0t: last_of_run mismatch: expected %b, actual %b", $time, w.run_last, tlast);
      end
      if (tuser[1] !== w.ovf) begin
        errors++;
        $display("%0t: overflow mismatch: expected %b, actual %b", $time, w.ovf, tuser[1]);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [1:0] out_tuser;

  postfix_scoreboard sb = new();

  int cycle_count = 0;
  int words_sent  = 0;
  int items_done  = 0;
  int idle_odds   = 0;
  bit quiet       = 0;

  infix_to_postfix_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic bit is_token(logic [7:0] sym);
    return (sym >= CH_UP_A && sym <= CH_UP_Z) || (sym >= CH_LO_A && sym <= CH_LO_Z) ||
           sym == CH_LPAREN || sym == CH_RPAREN || sym == CH_ADD || sym == CH_SUB ||
           sym == CH_MUL || sym == CH_DIV;
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 1)) return CH_UP_A + 8'($urandom_range(0, 25));
    return CH_LO_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  function automatic logic [7:0] pick_ignored();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(0, 32));
      1:       return 8'($urandom_range(8'h30, 8'h39));
      2:       return 8'($urandom_range(128, 255));
      3:       return 8'h40 + 8'($urandom_range(0, 1)) * 8'h20;  // just below 'A' / 'a'
      default: return 8'h5B + 8'($urandom_range(0, 1)) * 8'h20;  // just above 'Z' / 'z'
    endcase
  endfunction

  task automatic send_word(input logic [7:0] sym, input logic eoe);
    if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tlast  <= eoe;
    do @(posedge clk); while (!in_tready);
    sb.note_word(sym, eoe);
    words_sent++;
    if (is_token(sym)) items_done++;
  endtask

  task automatic send_string(input string s, input bit end_last);
    for (int i = 0; i < s.len(); i++) send_word(s[i], end_last && i == s.len() - 1);
  endtask

  // mostly well-formed expression with random content, occasionally left with open parens or mixed with random bytes
  task automatic send_expression();
    logic [7:0] toks [$];
    int         operands;
    int         open;
    operands = $urandom_range(1, 8);
    open     = 0;
    for (int n = 0; n < operands; n++) begin
      if (n > 0) toks.push_back(pick_op());
      while (open < 5 && $urandom_range(0, 3) == 0) begin
        toks.push_back(CH_LPAREN);
        open++;
      end
      toks.push_back(pick_letter());
      while (open > 0 && $urandom_range(0, 2) == 0) begin
        toks.push_back(CH_RPAREN);
        open--;
      end
    end
    if ($urandom_range(0, 5) != 0) repeat (open) toks.push_back(CH_RPAREN);
    if ($urandom_range(0, 7) == 0) toks.push_back(pick_ignored());
    foreach (toks[i]) begin
      if ($urandom_range(0, 15) == 0) send_word(8'($urandom_range(0, 255)), 1'b0);
      send_word(toks[i], i == toks.size() - 1);
    end
  endtask

  // broken token run: any order, any byte
  task automatic send_jumble();
    int         n;
    logic [7:0] sym;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0:       sym = pick_letter();
        1:       sym = pick_op();
        2:       sym = CH_LPAREN;
        3:       sym = CH_RPAREN;
        default: sym = 8'($urandom_range(0, 255));
      endcase
      send_word(sym, i == n - 1 || $urandom_range(0, 15) == 0);
    end
  endtask

  // fill the stack to the brim, then push '(' and '*' onto it (both dropped)
  task automatic send_overflow();
    repeat (STACK_DEPTH - 1) send_word(CH_LPAREN, 1'b0);
    send_word(pick_letter(), 1'b0);
    send_word(CH_ADD, 1'b0);
    send_word(CH_LPAREN, 1'b0);
    send_word(CH_MUL, 1'b0);
    send_word(pick_letter(), 1'b1);
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held       = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast, out_tuser);
      if (!held && words_sent >= 100) begin
        held       = 1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    bit overflowed;
    overflowed = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    idle_odds = 4;
    send_string("A+B*C", 1);    // higher priority waits on the stack
    send_string("a*b-z", 1);    // higher priority pops first
    send_string("(Z/x)", 1);    // matched parens
    send_string("Y-)((", 0);    // unmatched ')', then open parens left behind
    send_word(8'h00, 1'b1);     // flush drops the parens, empty end marker
    send_word(8'hFF, 1'b0);     // ignored, no words
    send_word(8'h7B, 1'b1);     // '{' ends an empty expression
    send_word(8'h40, 1'b0);
    send_word(8'h60, 1'b1);

    while (items_done < ITEMS) begin
      if (items_done >= 360) quiet = 1;
      if (!overflowed && items_done >= 300) begin
        overflowed = 1;
        send_overflow();
      end
      case ($urandom_range(0, 2))
        0:       idle_odds = 0;
        1:       idle_odds = 6;
        default: idle_odds = 2;
      endcase
      if ($urandom_range(0, 4) == 0) send_jumble();
      else send_expression();
    end
    in_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
